@@ rtl/core/lsr_pkg.sv @@
// lsr_pkg: shared types and constants of the literal stream replace block
// no dependencies; imported by every module under rtl/core
`default_nettype none

package lsr_pkg;

   localparam int PATTERN_MAX = 8;
   localparam int REPLACE_MAX = 8;
   localparam int WIN_DEPTH   = 8;

   // register indexes on the csr port
   localparam logic [2:0] CSR_SEARCH_PATTERN     = 3'd0;
   localparam logic [2:0] CSR_SEARCH_LENGTH      = 3'd1;
   localparam logic [2:0] CSR_REPLACEMENT_TEXT   = 3'd2;
   localparam logic [2:0] CSR_REPLACEMENT_LENGTH = 3'd3;
   localparam logic [2:0] CSR_OUT_CAPACITY       = 3'd4;

   typedef logic [7:0] byte_type;

   // configuration, lengths already clamped to their legal range
   typedef struct packed {
      logic [63:0] pattern;
      logic [3:0]  search_len;
      logic [63:0] repl;
      logic [3:0]  repl_len;
      logic [15:0] capacity;
   } cfg_type;

   // one run of result bytes handed from the engine to the run buffer
   typedef struct packed {
      logic                         load;
      logic [WIN_DEPTH-1:0][7:0]    bytes;
      logic [3:0]                   count;
      logic                         done;
      logic                         trunc;
   } run_type;

endpackage : lsr_pkg

`default_nettype wire

@@ rtl/core/lsr_csr.sv @@
// lsr_csr: configuration registers with length clamping
// depends on lsr_pkg
`default_nettype none

module lsr_csr (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           csr_wr_en,
   input  wire logic [2:0]     csr_index,
   input  wire logic [63:0]    csr_wr_data,
   output lsr_pkg::cfg_type    cfg,
   output logic                win_clear
);
   import lsr_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [3:0] len_raw;

   assign len_raw = csr_wr_data[3:0];

   always_comb begin
      cfg_in    = cfg_ff;
      win_clear = 1'b0;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SEARCH_PATTERN: begin
               cfg_in.pattern = csr_wr_data;
            end
            CSR_SEARCH_LENGTH: begin
               // zero acts as one, above max saturates
               if (len_raw == 4'd0) begin
                  cfg_in.search_len = 4'd1;
               end else if (len_raw > 4'(PATTERN_MAX)) begin
                  cfg_in.search_len = 4'(PATTERN_MAX);
               end else begin
                  cfg_in.search_len = len_raw;
               end
               win_clear = 1'b1;
            end
            CSR_REPLACEMENT_TEXT: begin
               cfg_in.repl = csr_wr_data;
            end
            CSR_REPLACEMENT_LENGTH: begin
               if (len_raw > 4'(REPLACE_MAX)) begin
                  cfg_in.repl_len = 4'(REPLACE_MAX);
               end else begin
                  cfg_in.repl_len = len_raw;
               end
            end
            CSR_OUT_CAPACITY: begin
               cfg_in.capacity = csr_wr_data[15:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern    <= '0;
         cfg_ff.search_len <= 4'd1;
         cfg_ff.repl       <= '0;
         cfg_ff.repl_len   <= 4'd0;
         cfg_ff.capacity   <= 16'd4096;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule : lsr_csr

`default_nettype wire

@@ rtl/core/lsr_engine.sv @@
// lsr_engine: input register, lookahead window, pattern compare and output limit
// depends on lsr_pkg; feeds a run of bytes to lsr_run_buffer
`default_nettype none

module lsr_engine (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire lsr_pkg::cfg_type cfg,
   input  wire logic          win_clear,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [7:0]    req_in_byte,
   input  wire logic          req_text_last,
   input  wire logic          run_free,
   output lsr_pkg::run_type   run
);
   import lsr_pkg::*;

   // input register
   logic       item_valid_ff, item_valid_in;
   logic [7:0] item_byte_ff;
   logic       item_last_ff;

   // window and per-text state
   byte_type   win_ff [WIN_DEPTH];
   byte_type   win_in [WIN_DEPTH];
   byte_type   win_ins [WIN_DEPTH];
   logic [3:0] cnt_ff, cnt_in, cnt_ins;
   logic [15:0] emitted_ff, emitted_in;
   logic       dropped_ff, dropped_in;

   logic        accept, fire, full, match, use_repl;
   logic [3:0]  n_cand, n_emit;
   logic [16:0] emitted_p1;
   logic [15:0] avail;

   assign fire      = item_valid_ff & run_free;
   assign req_stall = item_valid_ff & ~run_free;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (accept) begin
         item_valid_in = 1'b1;
      end else if (fire) begin
         item_valid_in = 1'b0;
      end
   end

   // insert the new byte behind the pending ones
   always_comb begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
         win_ins[i] = (4'(i) == cnt_ff) ? item_byte_ff : win_ff[i];
      end
   end

   assign cnt_ins = cnt_ff + 4'd1;
   assign full    = (cnt_ins == cfg.search_len);

   always_comb begin
      match = 1'b1;
      for (int i = 0; i < WIN_DEPTH; i++) begin
         if ((4'(i) < cfg.search_len) && (win_ins[i] != cfg.pattern[8*i +: 8])) begin
            match = 1'b0;
         end
      end
   end

   assign use_repl = full & match;

   // candidate byte count and next window
   always_comb begin
      win_in = win_ins;
      if (use_repl) begin
         n_cand = cfg.repl_len;
         cnt_in = 4'd0;
      end else if (full) begin
         n_cand = item_last_ff ? cfg.search_len : 4'd1;
         cnt_in = item_last_ff ? 4'd0 : cfg.search_len - 4'd1;
         for (int i = 0; i < WIN_DEPTH - 1; i++) begin
            win_in[i] = win_ins[i+1];
         end
      end else begin
         n_cand = item_last_ff ? cnt_ins : 4'd0;
         cnt_in = item_last_ff ? 4'd0 : cnt_ins;
      end
   end

   // room left under the capacity; accepted bytes come before any drop
   assign emitted_p1 = {1'b0, emitted_ff} + 17'd1;
   always_comb begin
      if ({1'b0, cfg.capacity} > emitted_p1) begin
         avail = cfg.capacity - emitted_ff - 16'd1;
      end else begin
         avail = 16'd0;
      end
      if (avail >= {12'd0, n_cand}) begin
         n_emit = n_cand;
      end else begin
         n_emit = avail[3:0];
      end
   end

   always_comb begin
      emitted_in = emitted_ff + {12'd0, n_emit};
      dropped_in = dropped_ff | (n_cand != n_emit);
      if (item_last_ff) begin
         emitted_in = 16'd0;
         dropped_in = 1'b0;
      end
   end

   always_comb begin
      run.load  = fire & (n_emit != 4'd0);
      run.count = n_emit;
      run.done  = item_last_ff;
      run.trunc = dropped_ff;
      for (int i = 0; i < WIN_DEPTH; i++) begin
         run.bytes[i] = use_repl ? cfg.repl[8*i +: 8] : win_ins[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         cnt_ff        <= 4'd0;
         emitted_ff    <= 16'd0;
         dropped_ff    <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         if (win_clear) begin
            cnt_ff <= 4'd0;
         end else if (fire) begin
            cnt_ff     <= cnt_in;
            emitted_ff <= emitted_in;
            dropped_ff <= dropped_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_byte_ff <= req_in_byte;
         item_last_ff <= req_text_last;
      end
      if (fire) begin
         win_ff <= win_in;
      end
   end

endmodule : lsr_engine

`default_nettype wire

@@ rtl/core/lsr_run_buffer.sv @@
// lsr_run_buffer: holds one run of up to eight result bytes and drains it
// depends on lsr_pkg; loaded by lsr_engine
`default_nettype none

module lsr_run_buffer (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire lsr_pkg::run_type run,
   output logic                 run_free,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_run_last,
   output logic                 rsp_text_done,
   output logic                 rsp_truncated
);
   import lsr_pkg::*;

   byte_type   bytes_ff [WIN_DEPTH];
   logic [3:0] rem_ff, rem_in;
   logic [2:0] idx_ff, idx_in;
   logic       done_ff, trunc_ff;
   logic       take;

   assign rsp_valid     = (rem_ff != 4'd0);
   assign take          = rsp_valid & ~rsp_stall;
   assign run_free      = (rem_ff == 4'd0) | ((rem_ff == 4'd1) & take);
   assign rsp_out_byte  = bytes_ff[idx_ff];
   assign rsp_run_last  = (rem_ff == 4'd1);
   assign rsp_text_done = rsp_run_last & done_ff;
   assign rsp_truncated = trunc_ff;

   always_comb begin
      rem_in = rem_ff;
      idx_in = idx_ff;
      if (run.load) begin
         rem_in = run.count;
         idx_in = 3'd0;
      end else if (take) begin
         rem_in = rem_ff - 4'd1;
         idx_in = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 4'd0;
         idx_ff <= 3'd0;
      end else begin
         rem_ff <= rem_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (run.load) begin
         for (int i = 0; i < WIN_DEPTH; i++) begin
            bytes_ff[i] <= run.bytes[i];
         end
         done_ff  <= run.done;
         trunc_ff <= run.trunc;
      end
   end

endmodule : lsr_run_buffer

`default_nettype wire

@@ rtl/core/literal_stream_replace.sv @@
// literal_stream_replace: top level of the literal search-and-replace stream block
// depends on lsr_pkg, lsr_csr, lsr_engine and lsr_run_buffer
`default_nettype none

// Text bytes enter on the req channel, one item per byte, and the bytes that
// survive search-and-replace leave on the rsp channel, one item per byte. A
// lookahead window holds up to search_length pending bytes; a full window equal
// to the pattern turns into the replacement bytes, a full window that differs
// releases its oldest byte, and the byte flagged text_last flushes the window.
// At most out_capacity minus one bytes go out per text, later ones are dropped;
// truncated shows on runs loaded after a drop. An item is registered on entry
// and worked out, once the run buffer is free, into a run of zero to eight
// result bytes, which the run buffer hands out one per cycle unless rsp stalls.
// Rate: one item per cycle while items give at most one byte and rsp does not
// stall; an item giving more holds the run buffer until its last byte is taken
// and the next waits. Items giving nothing pass at one per cycle when the run
// buffer is free. Configuration must be written between texts, not enforced.

module literal_stream_replace (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration write port
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wr_data,
   // text byte items in
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_text_last,
   // result byte items out
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_run_last,
   output logic             rsp_text_done,
   output logic             rsp_truncated
);
   import lsr_pkg::*;

   cfg_type cfg;
   run_type run;
   logic    win_clear;
   logic    run_free;

   // configuration registers; a new search length empties the window
   lsr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg),
      .win_clear   (win_clear)
   );

   // input register, window, compare and output limit in one pass
   lsr_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .win_clear     (win_clear),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_byte   (req_in_byte),
      .req_text_last (req_text_last),
      .run_free      (run_free),
      .run           (run)
   );

   // result register: drains each run one byte per cycle while rsp is not stalled
   lsr_run_buffer u_run_buffer (
      .clock         (clock),
      .reset         (reset),
      .run           (run),
      .run_free      (run_free),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_last  (rsp_run_last),
      .rsp_text_done (rsp_text_done),
      .rsp_truncated (rsp_truncated)
   );

endmodule : literal_stream_replace

`default_nettype wire
